// ===== design/bcld_pkg.sv =====
// shared types and constants for the button click and long-press detector
`default_nettype none

package bcld_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgDebounce  = 3'd0;
  localparam logic [2:0] CfgClickGap  = 3'd1;
  localparam logic [2:0] CfgLongPress = 3'd2;
  localparam logic [2:0] CfgMaxClicks = 3'd3;
  localparam logic [2:0] CfgActiveHi  = 3'd4;

  // reset values of the configuration registers
  localparam logic [15:0] DebounceRst  = 16'd50;
  localparam logic [15:0] ClickGapRst  = 16'd400;
  localparam logic [15:0] LongPressRst = 16'd800;
  localparam logic [6:0]  MaxClicksRst = 7'd1;
  localparam logic        ActiveHiRst  = 1'b0;

  // click counter ceiling
  localparam logic [6:0] ClickSat = 7'd127;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] click_gap_ms;
    logic [15:0] long_press_ms;
    logic [6:0]  max_clicks;
    logic        active_high;
  } cfg_t;

  typedef struct packed {
    logic       sequence_done;
    logic [6:0] sequence_clicks;
    logic       long_start;
    logic       long_during;
    logic       long_stop;
    logic       raw_pressed;
    logic       debounced_pressed;
    logic [6:0] clicks_so_far;
  } res_t;

endpackage

`default_nettype wire

// ===== design/button_click_longpress_detector.sv =====
// top level of the button click and long-press detector
`default_nettype none

// Takes one sample beat (pin level and millisecond time) per clock while the
// input is not stalled, and returns exactly one result beat for each, in
// order. A sample sits in an input register, the single state machine step is
// computed from it combinationally, and the result lands in the result
// register when that slot is free. Throughput is one sample per clock while the
// output is not stalled; a stall on the output holds the input register and
// stalls the input side only once both registers are full. Configuration
// registers are written through the cfg port, which is always ready.

module button_click_longpress_detector (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        pin_level_i,
  input  wire logic [31:0] now_ms_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             sequence_done_o,
  output logic [6:0]       sequence_clicks_o,
  output logic             long_start_o,
  output logic             long_during_o,
  output logic             long_stop_o,
  output logic             raw_pressed_o,
  output logic             debounced_pressed_o,
  output logic [6:0]       clicks_so_far_o,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  bcld_pkg::cfg_t cfg;
  bcld_pkg::res_t res;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_pin_q;
  logic [31:0] s1_now_q;
  logic        out_valid_q, out_valid_d;
  logic        adv;

  assign cfg_ready_o = 1'b1;

  bcld_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sample moves into the result register when that slot is free
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // handshake valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_pin_q <= pin_level_i;
      s1_now_q <= now_ms_i;
    end
  end

  bcld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .pin_level_i (s1_pin_q),
    .now_ms_i    (s1_now_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  assign out_valid_o         = out_valid_q;
  assign sequence_done_o     = res.sequence_done;
  assign sequence_clicks_o   = res.sequence_clicks;
  assign long_start_o        = res.long_start;
  assign long_during_o       = res.long_during;
  assign long_stop_o         = res.long_stop;
  assign raw_pressed_o       = res.raw_pressed;
  assign debounced_pressed_o = res.debounced_pressed;
  assign clicks_so_far_o     = res.clicks_so_far;

  // a finished sequence always carries a click and leaves the machine cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sequence_done_o |->
      sequence_clicks_o != 7'd0 && clicks_so_far_o == 7'd0 && !raw_pressed_o)
    else $error("sequence end without clicks or with state left over");

  // long press start sets the debounced flag in the same beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && long_start_o |-> debounced_pressed_o && !sequence_done_o)
    else $error("long press start without debounced flag");

  // the input side stalls only while the input register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== design/bcld_cfg_regs.sv =====
// configuration register file of the button detector
`default_nettype none

module bcld_cfg_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [2:0]       wr_index_i,
  input  wire logic [15:0]      wr_data_i,
  output bcld_pkg::cfg_t        cfg_o
);

  bcld_pkg::cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        bcld_pkg::CfgDebounce:  cfg_d.debounce_ms   = wr_data_i;
        bcld_pkg::CfgClickGap:  cfg_d.click_gap_ms  = wr_data_i;
        bcld_pkg::CfgLongPress: cfg_d.long_press_ms = wr_data_i;
        bcld_pkg::CfgMaxClicks: cfg_d.max_clicks    = wr_data_i[6:0];
        bcld_pkg::CfgActiveHi:  cfg_d.active_high   = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= bcld_pkg::DebounceRst;
      cfg_q.click_gap_ms  <= bcld_pkg::ClickGapRst;
      cfg_q.long_press_ms <= bcld_pkg::LongPressRst;
      cfg_q.max_clicks    <= bcld_pkg::MaxClicksRst;
      cfg_q.active_high   <= bcld_pkg::ActiveHiRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/bcld_core.sv =====
// button state machine: one sample step per advance, with result register
`default_nettype none

module bcld_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             pin_level_i,
  input  wire logic [31:0]      now_ms_i,
  input  wire bcld_pkg::cfg_t   cfg_i,
  output bcld_pkg::res_t        res_o
);

  typedef enum logic [2:0] {
    StIdle     = 3'd0,
    StDown     = 3'd1,
    StUp       = 3'd2,
    StCount    = 3'd3,
    StPress    = 3'd4,
    StPressEnd = 3'd5
  } state_e;

  state_e         state_q, state_d;
  state_e         prev_q, prev_d;
  logic [6:0]     count_q, count_d;
  logic [31:0]    start_q, start_d;
  logic           raw_q, raw_d;
  logic           deb_q, deb_d;
  logic           long_q, long_d;
  bcld_pkg::res_t res_q, res_d;

  logic        pressed;
  logic [31:0] wait_ms;
  logic        lt_deb;
  logic        done;

  assign pressed = (pin_level_i == cfg_i.active_high);
  assign wait_ms = now_ms_i - start_q;
  assign lt_deb  = (wait_ms < {16'd0, cfg_i.debounce_ms});

  // next state and result for one sample
  always_comb begin
    state_d = state_q;
    prev_d  = prev_q;
    count_d = count_q;
    start_d = start_q;
    raw_d   = raw_q;
    deb_d   = deb_q;
    long_d  = long_q;
    done    = 1'b0;
    res_d   = '0;

    case (state_q)
      StIdle: begin
        if (pressed) begin
          prev_d  = state_q;
          state_d = StDown;
          start_d = now_ms_i;
          count_d = '0;
          raw_d   = 1'b1;
        end
      end
      StDown: begin
        if (!pressed && lt_deb) begin
          prev_d  = state_q;
          state_d = prev_q;
        end else if (!pressed) begin
          prev_d  = state_q;
          state_d = StUp;
          start_d = now_ms_i;
        end else if (wait_ms > {16'd0, cfg_i.long_press_ms}) begin
          res_d.long_start = 1'b1;
          prev_d  = state_q;
          state_d = StPress;
          deb_d   = 1'b1;
        end
      end
      StUp: begin
        if (pressed && lt_deb) begin
          prev_d  = state_q;
          state_d = prev_q;
        end else if (!lt_deb) begin
          if (count_q != bcld_pkg::ClickSat) begin
            count_d = count_q + 7'd1;
          end
          prev_d  = state_q;
          state_d = StCount;
        end
      end
      StCount: begin
        if (pressed) begin
          prev_d  = state_q;
          state_d = StDown;
          start_d = now_ms_i;
        end else if (wait_ms > {16'd0, cfg_i.click_gap_ms}
                     || count_q == cfg_i.max_clicks) begin
          res_d.sequence_done   = 1'b1;
          res_d.sequence_clicks = count_q;
          done = 1'b1;
        end
      end
      StPress: begin
        if (!pressed) begin
          prev_d  = state_q;
          state_d = StPressEnd;
          start_d = now_ms_i;
        end else begin
          res_d.long_during = 1'b1;
          long_d = 1'b1;
        end
      end
      StPressEnd: begin
        if (pressed && lt_deb) begin
          prev_d  = state_q;
          state_d = prev_q;
        end else if (!lt_deb) begin
          res_d.long_stop = 1'b1;
          done = 1'b1;
        end
      end
      default: begin
        prev_d  = state_q;
        state_d = StIdle;
      end
    endcase

    // end of sequence or long press: back to reset values
    if (done) begin
      state_d = StIdle;
      prev_d  = StIdle;
      count_d = '0;
      start_d = '0;
      raw_d   = 1'b0;
      deb_d   = 1'b0;
      long_d  = 1'b0;
    end

    res_d.raw_pressed       = raw_d;
    res_d.debounced_pressed = deb_d;
    res_d.clicks_so_far     = count_d;
  end

  // state and result register, updated once per sample beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      prev_q  <= StIdle;
      count_q <= '0;
      start_q <= '0;
      raw_q   <= 1'b0;
      deb_q   <= 1'b0;
      long_q  <= 1'b0;
      res_q   <= '0;
    end else if (adv_i) begin
      state_q <= state_d;
      prev_q  <= prev_d;
      count_q <= count_d;
      start_q <= start_d;
      raw_q   <= raw_d;
      deb_q   <= deb_d;
      long_q  <= long_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
